// ===== rtl/ftd_pkg.sv =====
// ----------------------------------------------------------------------------
// ftd_pkg
// Shared types and constants of the fieldbus telegram deframer.
// ----------------------------------------------------------------------------
package ftd_pkg;

	// Telegram store size and the widths that follow from it
	localparam int MAX_FRAME_BYTES = 23;
	localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
	localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

	// Header bytes 0..7 are fetched after the last byte
	localparam int HDR_BYTES = 8;
	localparam int HDR_IDX_W = 3;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 3'd7;

	// Payload starts at byte 8
	localparam logic [4:0] PAY_BASE = 5'd8;

	localparam logic [7:0] XOR_SEED    = 8'hFF;
	localparam logic [7:0] INLINE_MASK = 8'h3F;

	typedef enum logic [1:0] {
		KIND_INLINE  = 2'd0,
		KIND_PLAIN   = 2'd1,
		KIND_PAYLOAD = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		STAT_OK           = 2'd0,
		STAT_TOO_LONG     = 2'd1,
		STAT_CK_BAD       = 2'd2,
		STAT_LEN_MISMATCH = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR_RD,
		S_HDR_WAIT,
		S_HDR_OUT,
		S_PAY_RD,
		S_PAY_LD
	} state_t;

	typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_t;

	// Store write request from the receive tracker
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	// Telegram verdict as known at the last byte
	typedef struct packed {
		status_t          pre_status;
		logic [LEN_W-1:0] fill;
	} rx_stat_t;

	// One result word
	typedef struct packed {
		result_kind_t kind;
		status_t      status;
		logic [3:0]   source_area;
		logic [3:0]   source_line;
		logic [7:0]   source_device;
		logic [4:0]   target_main;
		logic [2:0]   target_middle;
		logic [7:0]   target_sub;
		logic [1:0]   priority_level;
		logic [3:0]   payload_count;
		logic [7:0]   data_value;
		logic         last_of_run;
	} out_word_t;

endpackage

// ===== rtl/ftd_rx_track.sv =====
// ----------------------------------------------------------------------------
// ftd_rx_track
// Byte count, running checksum and overflow tracking for the receive side.
// ----------------------------------------------------------------------------
module ftd_rx_track import ftd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	input  logic       clear,
	output wr_req_t    wr_req,
	output rx_stat_t   rx_stat
);

	logic [LEN_W-1:0] byte_count_q;
	logic [7:0]       xor_q;
	logic             ovf_q;
	status_t          pre_status_q;
	logic             full;
	logic             too_long;
	logic             ck_ok;

	assign full     = byte_count_q >= LEN_W'(MAX_FRAME_BYTES);
	assign too_long = ovf_q || full;
	assign ck_ok    = (byte_count_q == '0) ? (rx_byte == 8'h00) : (xor_q == rx_byte);

	// Store every byte that fits; the last byte only if the telegram is not too long
	always_comb begin
		wr_req.en   = accept && !full && !(end_of_frame && ovf_q);
		wr_req.addr = byte_count_q[ADDR_W-1:0];
		wr_req.data = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			xor_q        <= XOR_SEED;
			ovf_q        <= 1'b0;
			pre_status_q <= STAT_OK;
		end else if (clear) begin
			byte_count_q <= '0;
			xor_q        <= XOR_SEED;
			ovf_q        <= 1'b0;
		end else if (accept) begin
			if (wr_req.en) begin
				byte_count_q <= byte_count_q + LEN_W'(1);
			end
			if (!end_of_frame) begin
				xor_q <= xor_q ^ rx_byte;
				if (full) begin
					ovf_q <= 1'b1;
				end
			end else begin
				pre_status_q <= too_long ? STAT_TOO_LONG : (ck_ok ? STAT_OK : STAT_CK_BAD);
			end
		end
	end

	assign rx_stat.pre_status = pre_status_q;
	assign rx_stat.fill       = byte_count_q;

endmodule

// ===== rtl/ftd_hdr_decode.sv =====
// ----------------------------------------------------------------------------
// ftd_hdr_decode
// Length check and header field extraction from the fetched header bytes.
// ----------------------------------------------------------------------------
module ftd_hdr_decode import ftd_pkg::*; (
	input  hdr_bytes_t hdr_bytes,
	input  rx_stat_t   rx_stat,
	output out_word_t  hdr_word
);

	logic [4:0] apdu;
	logic       big;
	logic       mismatch;
	status_t    stat;

	assign apdu     = {1'b0, hdr_bytes[5][3:0]} + 5'd1;
	assign big      = apdu > 5'd2;
	assign mismatch = big && ({(6-LEN_W)'(0), rx_stat.fill} != ({1'b0, apdu} + 6'd7));

	always_comb begin
		if (rx_stat.pre_status != STAT_OK) begin
			stat = rx_stat.pre_status;
		end else if (mismatch) begin
			stat = STAT_LEN_MISMATCH;
		end else begin
			stat = STAT_OK;
		end
	end

	always_comb begin
		hdr_word             = '0;
		hdr_word.kind        = KIND_PLAIN;
		hdr_word.status      = stat;
		hdr_word.last_of_run = 1'b1;
		if (stat == STAT_OK) begin
			// Zero address fields that the telegram is too short to carry
			if (rx_stat.fill >= LEN_W'(3)) begin
				hdr_word.source_area   = hdr_bytes[1][7:4];
				hdr_word.source_line   = hdr_bytes[1][3:0];
				hdr_word.source_device = hdr_bytes[2];
			end
			if (rx_stat.fill >= LEN_W'(5)) begin
				hdr_word.target_main   = hdr_bytes[3][7:3];
				hdr_word.target_middle = hdr_bytes[3][2:0];
				hdr_word.target_sub    = hdr_bytes[4];
			end
			hdr_word.priority_level = hdr_bytes[0][3:2];
			if (apdu == 5'd2) begin
				hdr_word.kind       = KIND_INLINE;
				hdr_word.data_value = hdr_bytes[7] & INLINE_MASK;
			end else if (big) begin
				hdr_word.payload_count = 4'(apdu - 5'd2);
				hdr_word.last_of_run   = 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fieldbus_telegram_deframer.sv =====
// ----------------------------------------------------------------------------
// fieldbus_telegram_deframer
// Receives a group telegram byte by byte, checks it and emits a header word
// followed by its payload bytes.
// ----------------------------------------------------------------------------
//
// channel  | handshake             | word
// ---------+-----------------------+--------------------------------------------
// input    | in_valid / in_stall   | rx_byte, end_of_frame
// output   | out_valid / out_stall | result_kind, status, address fields,
//          |                       | priority_level, payload_count, data_value,
//          |                       | last_of_run
//
// A byte that is not the last one is taken every cycle and written to the
// frame store while it fits. After the last byte the input stalls while
// header bytes 0..7 are read back through the store's single read port; after
// a wait state the header word is loaded, then each payload word is read and loaded.
// Positions not received this telegram read as zero through a fill count, so
// the store needs no clearing pass after reset or between telegrams.
// A stalled output word holds; the next payload read issues only once it is taken.
// ----------------------------------------------------------------------------
module fieldbus_telegram_deframer import ftd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [1:0] status,
	output logic [3:0] source_area,
	output logic [3:0] source_line,
	output logic [7:0] source_device,
	output logic [4:0] target_main,
	output logic [2:0] target_middle,
	output logic [7:0] target_sub,
	output logic [1:0] priority_level,
	output logic [3:0] payload_count,
	output logic [7:0] data_value,
	output logic       last_of_run
);

	state_t               state_q, state_d;
	logic                 in_accept;
	logic                 clear;
	wr_req_t              wr_req;
	rx_stat_t             rx_stat;

	// Frame store and its registered read port
	logic [7:0]           frame_mem [MAX_FRAME_BYTES];
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic [7:0]           rd_data_q;

	// Header fetch
	logic [HDR_IDX_W-1:0] rd_ptr_q;
	logic                 rd_vld_s1;
	logic [HDR_IDX_W-1:0] rd_idx_s1;
	hdr_bytes_t           hdr_bytes_q;
	out_word_t            hdr_word;

	// Emission
	logic [3:0]           emit_idx_q;
	logic [3:0]           count_q;
	logic                 pay_last;
	logic                 out_free;
	logic                 load_hdr;
	logic                 load_pay;
	logic                 out_valid_q;
	out_word_t            out_q;
	out_word_t            pay_word;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign pay_last  = (emit_idx_q + 4'd1) == count_q;

	ftd_rx_track u_rx_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.rx_byte      (rx_byte),
		.end_of_frame (end_of_frame),
		.clear        (clear),
		.wr_req       (wr_req),
		.rx_stat      (rx_stat)
	);

	ftd_hdr_decode u_hdr_decode (
		.hdr_bytes (hdr_bytes_q),
		.rx_stat   (rx_stat),
		.hdr_word  (hdr_word)
	);

	// Writes happen only while receiving and reads only after the last
	// byte, so a read never meets a write to the same entry.
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			frame_mem[wr_req.addr] <= wr_req.data;
		end
		if (rd_en) begin
			rd_data_q <= frame_mem[rd_addr];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && end_of_frame) begin
					state_d = S_HDR_RD;
				end
			end
			S_HDR_RD: begin
				if (rd_ptr_q == HDR_LAST_IDX) begin
					state_d = S_HDR_WAIT;
				end
			end
			S_HDR_WAIT: state_d = S_HDR_OUT;
			S_HDR_OUT: begin
				if (out_free) begin
					state_d = (hdr_word.payload_count != 4'd0) ? S_PAY_RD : S_IDLE;
				end
			end
			S_PAY_RD: begin
				if (out_free) begin
					state_d = S_PAY_LD;
				end
			end
			S_PAY_LD: state_d = pay_last ? S_IDLE : S_PAY_RD;
			default:  state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = ADDR_W'(rd_ptr_q);
		load_hdr = 1'b0;
		load_pay = 1'b0;
		clear    = 1'b0;
		unique case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_HDR_RD: rd_en = 1'b1;
			S_HDR_WAIT: ;
			S_HDR_OUT: begin
				load_hdr = out_free;
				clear    = out_free && (hdr_word.payload_count == 4'd0);
			end
			S_PAY_RD: begin
				rd_en   = out_free;
				rd_addr = ADDR_W'(PAY_BASE + {1'b0, emit_idx_q});
			end
			S_PAY_LD: begin
				load_pay = 1'b1;
				clear    = pay_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the header read pointer; it wraps back to zero by itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_HDR_RD);
			if (state_q == S_HDR_RD) begin
				rd_ptr_q <= rd_ptr_q + HDR_IDX_W'(1);
			end
		end
	end

	// Capture header bytes; drop anything beyond this telegram's fill
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr_q;
		if (rd_vld_s1) begin
			hdr_bytes_q[rd_idx_s1] <= (LEN_W'(rd_idx_s1) < rx_stat.fill) ? rd_data_q : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
			count_q    <= '0;
		end else begin
			if (load_hdr) begin
				count_q <= hdr_word.payload_count;
			end
			if (clear) begin
				emit_idx_q <= '0;
			end else if (load_pay) begin
				emit_idx_q <= emit_idx_q + 4'd1;
			end
		end
	end

	always_comb begin
		pay_word             = '0;
		pay_word.kind        = KIND_PAYLOAD;
		pay_word.status      = STAT_OK;
		pay_word.data_value  = rd_data_q;
		pay_word.last_of_run = pay_last;
	end

	// Output register: hold while stalled, reload only when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_hdr || load_pay) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_hdr) begin
			out_q <= hdr_word;
		end else if (load_pay) begin
			out_q <= pay_word;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_q.kind;
	assign status         = out_q.status;
	assign source_area    = out_q.source_area;
	assign source_line    = out_q.source_line;
	assign source_device  = out_q.source_device;
	assign target_main    = out_q.target_main;
	assign target_middle  = out_q.target_middle;
	assign target_sub     = out_q.target_sub;
	assign priority_level = out_q.priority_level;
	assign payload_count  = out_q.payload_count;
	assign data_value     = out_q.data_value;
	assign last_of_run    = out_q.last_of_run;

	// A waiting word must never be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_hdr || load_pay) |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");

	// After the last byte, input stalls until the telegram is emitted
	a_stall_after_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && end_of_frame) |=> in_stall)
		else $error("input accepted right after end of frame");

	// Payload index stays below the telegram's payload count
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAY_RD || state_q == S_PAY_LD) |-> (emit_idx_q < count_q))
		else $error("payload index past count");

	// Fill never exceeds the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stat.fill <= LEN_W'(MAX_FRAME_BYTES))
		else $error("fill count beyond store depth");

	// Payload words only follow a good header
	a_pay_status: assert property (@(posedge clk) disable iff (!arst_n)
		load_pay |-> (count_q != 4'd0))
		else $error("payload load without payload count");

endmodule
